### hw/rtl/otsu_pkg.sv
// ============================================================================
// Otsu threshold finder package
// Shared widths and constants for the histogram and the gray conversion.
// ============================================================================
`default_nettype none

package otsu_pkg;

    // histogram geometry
    localparam int BINS     = 256;
    localparam int BIN_W    = 8;
    localparam int PIX_W    = 8;

    // gray conversion weights, sum of weights is 1 << GRAY_SHIFT
    localparam int GRAY_W     = 16;
    localparam int COEF_R     = 77;
    localparam int COEF_G     = 150;
    localparam int COEF_B     = 29;
    localparam int GRAY_SHIFT = 8;

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

endpackage

`default_nettype wire

### hw/rtl/otsu_if.sv
// ============================================================================
// Otsu threshold finder channels
// Valid/ready channels for pixels, results and the mode register write.
// ============================================================================
`default_nettype none

interface otsu_pix_if;
    import otsu_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface otsu_res_if;
    import otsu_pkg::*;
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] threshold;
    logic             no_split;
    logic             count_overflow;

    modport source (output valid, threshold, no_split, count_overflow, input ready);
    modport sink   (input valid, threshold, no_split, count_overflow, output ready);
endinterface

interface otsu_cfg_if;
    logic valid;
    logic ready;
    logic input_is_rgb;

    modport source (output valid, input_is_rgb, input ready);
    modport sink   (input valid, input_is_rgb, output ready);
endinterface

`default_nettype wire

### hw/rtl/otsu_mul.sv
// ============================================================================
// Otsu shared multiplier
// Radix-2 shift-and-add multiplier; one multiplier bit per cycle, exact while P_W holds the full product.
// ============================================================================
`default_nettype none

module otsu_mul #(
    parameter int A_W = 140,
    parameter int B_W = 70,
    parameter int P_W = 202
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    output logic                o_busy,
    output logic                o_done,
    output logic [P_W-1:0]      o_product
);

    logic [P_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [P_W-1:0] r_acc;
    logic           r_busy;

    // load on start, else add and shift until the multiplier runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[P_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[B_W-1:1]};
        end
    end

    assign o_busy    = r_busy;
    assign o_done    = r_busy && (r_b == '0);
    assign o_product = r_acc;

endmodule

`default_nettype wire

### hw/rtl/otsu_threshold_finder_unit.sv
// ============================================================================
// Otsu threshold finder
// Gray histogram of one image, then an exact Otsu threshold sweep.
// ============================================================================
//  channel  | dir | payload                                  | beat when
//  i_pix    | in  | red, green, blue, last_pixel             | valid && ready
//  o_res    | out | threshold, no_split, count_overflow      | valid && ready
//  i_cfg    | in  | input_is_rgb                             | valid && ready
//
//  Each pixel is a histogram memory read, then a write back.
//  The last pixel then runs a level sum pass over all bins and a 256-step sweep;
//  each step with two non-empty classes runs up to six products on the one
//  shift-add multiplier, one multiplier bit per cycle.
//  After reset a clearing pass zeroes the histogram; no pixel is taken then.
//  The sweep zeroes each bin as it reads it. The result waits in an output
//  register, so the next image streams in meanwhile; a sweep that ends while
//  a result still waits stalls until that result beat.
// ============================================================================
`default_nettype none

module otsu_threshold_finder_unit #(
    parameter int MAX_PIXELS_LOG2 = 20
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    otsu_pix_if.sink   i_pix,
    otsu_res_if.source o_res,
    otsu_cfg_if.sink   i_cfg
);
    import otsu_pkg::*;

    localparam int CW = MAX_PIXELS_LOG2 + 1;  // count width
    localparam int SW = CW + BIN_W;           // level sum width
    localparam int DW = SW + CW;              // class difference width
    localparam int NW = 2 * DW;               // numerator width
    localparam int EW = 2 * CW;               // denominator width
    localparam int PW = NW + EW;              // cross product width

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_INC     = 14'b00000000000100,
        S_SUM_RD  = 14'b00000000001000,
        S_SUM_ACC = 14'b00000000010000,
        S_EVAL    = 14'b00000000100000,
        S_M_PA    = 14'b00000001000000,
        S_M_PB    = 14'b00000010000000,
        S_M_NUM   = 14'b00000100000000,
        S_M_DEN   = 14'b00001000000000,
        S_M_LHS   = 14'b00010000000000,
        S_M_RHS   = 14'b00100000000000,
        S_BIN_RD  = 14'b01000000000000,
        S_BIN_ACC = 14'b10000000000000
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    logic             r_rgb;
    logic [BIN_W-1:0] r_t;
    logic [BIN_W-1:0] r_gray;
    logic             r_last;
    logic [CW-1:0]    r_total;
    logic             r_ovf;
    logic [SW-1:0]    r_sum;
    logic [CW-1:0]    r_n0;
    logic [SW-1:0]    r_s0;
    logic [DW-1:0]    r_pa;
    logic [NW-1:0]    r_num;
    logic [EW-1:0]    r_den;
    logic [PW-1:0]    r_lhs;
    logic             r_have;
    logic [NW-1:0]    r_best_num;
    logic [EW-1:0]    r_best_den;
    logic [BIN_W-1:0] r_best_t;

    // output register
    logic [BIN_W-1:0] r_res_thr;
    logic             r_res_no_split;
    logic             r_res_ovf;

    // histogram memory
    logic [CW-1:0]    r_mem [BINS];
    logic [CW-1:0]    r_rd_data;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    logic [CW-1:0]    wr_data;

    // shared multiplier
    logic          mul_start;
    logic [NW-1:0] mul_a;
    logic [DW-1:0] mul_b;
    logic          mul_busy;
    logic          mul_done;
    logic [PW-1:0] mul_p;

    logic [GRAY_W-1:0] gray_mix;
    logic [BIN_W-1:0]  gray_in;
    logic              pix_beat;
    logic [CW-1:0]     n1;
    logic [DW-1:0]     pb;
    logic [DW-1:0]     d_abs;

    // gray level of the incoming pixel
    assign gray_mix = GRAY_W'(COEF_R) * GRAY_W'(i_pix.red)
                    + GRAY_W'(COEF_G) * GRAY_W'(i_pix.green)
                    + GRAY_W'(COEF_B) * GRAY_W'(i_pix.blue);
    assign gray_in  = r_rgb ? gray_mix[GRAY_SHIFT +: BIN_W] : i_pix.red;

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_beat    = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    // class sizes and the class difference
    assign n1    = r_total - r_n0;
    assign pb    = mul_p[DW-1:0];
    assign d_abs = (r_pa >= pb) ? (r_pa - pb) : (pb - r_pa);

    // hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb <= 1'b0;
        end else if (i_cfg.valid) begin
            r_rgb <= i_cfg.input_is_rgb;
        end
    end

    // memory port selection
    always_comb begin
        rd_addr = r_t;
        wr_en   = 1'b0;
        wr_addr = r_t;
        wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_addr = gray_in;
            end
            S_INC: begin
                wr_en   = !r_total[CW-1];
                wr_addr = r_gray;
                wr_data = r_rd_data + CW'(1);
            end
            S_BIN_ACC: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_addr = r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_EVAL: begin
                mul_start = (r_n0 != '0) && (n1 != '0);
                mul_a     = NW'(r_s0);
                mul_b     = DW'(n1);
            end
            S_M_PA: begin
                mul_start = mul_done;
                mul_a     = NW'(r_sum - r_s0);
                mul_b     = DW'(r_n0);
            end
            S_M_PB: begin
                mul_start = mul_done;
                mul_a     = NW'(d_abs);
                mul_b     = d_abs;
            end
            S_M_NUM: begin
                mul_start = mul_done;
                mul_a     = NW'(r_n0);
                mul_b     = DW'(n1);
            end
            S_M_DEN: begin
                mul_start = mul_done && r_have;
                mul_a     = r_num;
                mul_b     = DW'(r_best_den);
            end
            S_M_LHS: begin
                mul_start = mul_done;
                mul_a     = r_best_num;
                mul_b     = DW'(r_den);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    otsu_mul #(
        .A_W (NW),
        .B_W (DW),
        .P_W (PW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_busy    (mul_busy),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_t         <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_t <= r_t + BIN_W'(1);
                    if (r_t == BIN_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pix_beat) begin
                        r_gray  <= gray_in;
                        r_last  <= i_pix.last_pixel;
                        r_state <= S_INC;
                    end
                end
                S_INC: begin
                    // count the pixel, or drop it once full
                    if (r_total[CW-1]) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_total <= r_total + CW'(1);
                    end
                    if (r_last) begin
                        r_t     <= '0;
                        r_sum   <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_sum <= r_sum + SW'(r_t) * SW'(r_rd_data);
                    r_t   <= r_t + BIN_W'(1);
                    if (r_t == BIN_LAST) begin
                        r_n0    <= '0;
                        r_s0    <= '0;
                        r_have  <= 1'b0;
                        r_state <= S_EVAL;
                    end else begin
                        r_state <= S_SUM_RD;
                    end
                end
                S_EVAL: begin
                    r_state <= mul_start ? S_M_PA : S_BIN_RD;
                end
                S_M_PA: begin
                    if (mul_done) begin
                        r_pa    <= mul_p[DW-1:0];
                        r_state <= S_M_PB;
                    end
                end
                S_M_PB: begin
                    if (mul_done) begin
                        r_state <= S_M_NUM;
                    end
                end
                S_M_NUM: begin
                    if (mul_done) begin
                        r_num   <= mul_p[NW-1:0];
                        r_state <= S_M_DEN;
                    end
                end
                S_M_DEN: begin
                    if (mul_done) begin
                        r_den <= mul_p[EW-1:0];
                        if (r_have) begin
                            r_state <= S_M_LHS;
                        end else begin
                            r_have     <= 1'b1;
                            r_best_num <= r_num;
                            r_best_den <= mul_p[EW-1:0];
                            r_best_t   <= r_t;
                            r_state    <= S_BIN_RD;
                        end
                    end
                end
                S_M_LHS: begin
                    if (mul_done) begin
                        r_lhs   <= mul_p;
                        r_state <= S_M_RHS;
                    end
                end
                S_M_RHS: begin
                    // keep the first strict maximum
                    if (mul_done) begin
                        if (r_lhs > mul_p) begin
                            r_best_num <= r_num;
                            r_best_den <= r_den;
                            r_best_t   <= r_t;
                        end
                        r_state <= S_BIN_RD;
                    end
                end
                S_BIN_RD: begin
                    r_state <= S_BIN_ACC;
                end
                S_BIN_ACC: begin
                    if (r_t != BIN_LAST) begin
                        // advance the class-zero totals and clear the bin
                        r_n0    <= r_n0 + r_rd_data;
                        r_s0    <= r_s0 + SW'(r_t) * SW'(r_rd_data);
                        r_t     <= r_t + BIN_W'(1);
                        r_state <= S_EVAL;
                    end else if (!r_out_valid) begin
                        // hand the result over and start a fresh image
                        r_res_thr      <= r_have ? r_best_t : '0;
                        r_res_no_split <= !r_have;
                        r_res_ovf      <= r_ovf;
                        r_out_valid    <= 1'b1;
                        r_total        <= '0;
                        r_ovf          <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.threshold      = r_res_thr;
    assign o_res.no_split       = r_res_no_split;
    assign o_res.count_overflow = r_res_ovf;

    // the multiplier is restarted only once its product is complete
    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> (!mul_busy || mul_done))
        else $error("multiplier restarted while busy");

    // a waiting result holds steady until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid
            && $stable(o_res.threshold) && $stable(o_res.no_split)
            && $stable(o_res.count_overflow)))
        else $error("result changed while waiting");

    // the pixel total never passes the capacity
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total[CW-1] |-> (r_total[CW-2:0] == '0))
        else $error("pixel total beyond capacity");

    // the sweep end waits while the output register is full
    a_sweep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BIN_ACC) && (r_t == BIN_LAST) && r_out_valid)
            |=> (r_state == S_BIN_ACC))
        else $error("result overwritten while pending");

endmodule

`default_nettype wire
